### rtl/mba_pkg.sv
// Shared types and constants for the multichannel block averager.
// No dependencies; imported by mba_queue, mba_front, mba_back and the top level.
`timescale 1ns / 1ps

package mba_pkg;

  // Fixed field widths of the streaming interface.
  localparam int CHAN_W     = 4;
  localparam int MAX_DATA_W = 24;  // widest sample or count the block supports

  // Configuration register indexes.
  localparam logic REG_FIRST_CHANNEL = 1'b0;
  localparam logic REG_LAST_CHANNEL  = 1'b1;

  // Request kind carried in tuser.
  localparam logic FUNC_SAMPLE    = 1'b0;
  localparam logic FUNC_SET_COUNT = 1'b1;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic                  set_count;  // 1: load target, 0: accumulate sample
    logic [CHAN_W-1:0]     ch;
    logic [MAX_DATA_W-1:0] data;       // sign-extended sample or clamped target
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_EMIT
  } back_state_t;

endpackage

### rtl/mba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mba_queue.sv
// Two-entry request queue between the front and the back.
// Depends on mba_pkg for cmd_t.
`timescale 1ns / 1ps

module mba_queue
  import mba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### rtl/mba_front.sv
// Front end: configuration registers, input acceptance and classification.
// Depends on mba_pkg; pushes classified requests into mba_queue.
`timescale 1ns / 1ps

module mba_front
  import mba_pkg::*;
#(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  input  logic [((CHAN_W+SAMPLE_BITS+COUNT_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                                          s_tuser,
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic                                          cfg_index,
  input  logic [CHAN_W-1:0]                             cfg_data,
  input  logic                                          q_full,
  output logic                                          q_push,
  output cmd_t                                          q_cmd
);

  logic [CHAN_W-1:0]      first_channel;
  logic [CHAN_W-1:0]      last_channel;
  logic [CHAN_W-1:0]      ch;
  logic [SAMPLE_BITS-1:0] smp;
  logic [COUNT_BITS-1:0]  cnt;
  logic [COUNT_BITS-1:0]  target;
  logic                   ch_exists;
  logic                   in_window;
  logic                   keep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_channel <= '0;
      last_channel  <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIRST_CHANNEL: first_channel <= cfg_data;
        REG_LAST_CHANNEL:  last_channel  <= cfg_data;
        default:           first_channel <= first_channel;
      endcase
    end
  end

  assign ch  = s_tdata[CHAN_W-1:0];
  assign smp = s_tdata[CHAN_W +: SAMPLE_BITS];
  assign cnt = s_tdata[CHAN_W+SAMPLE_BITS +: COUNT_BITS];

  // zero target means emit every sample
  assign target    = (cnt == '0) ? COUNT_BITS'(1) : cnt;
  assign ch_exists = (32'(ch) < CHANNELS);
  assign in_window = (ch >= first_channel) && (ch <= last_channel);
  // set-count loads regardless of window; samples outside it are dropped
  assign keep      = ch_exists && ((s_tuser == FUNC_SET_COUNT) || in_window);

  assign s_tready = ~q_full;
  assign q_push   = s_tvalid && s_tready && keep;

  always_comb begin
    q_cmd.set_count = (s_tuser == FUNC_SET_COUNT);
    q_cmd.ch        = ch;
    q_cmd.data      = (s_tuser == FUNC_SET_COUNT) ? MAX_DATA_W'(target)
                                                  : MAX_DATA_W'($signed(smp));
  end

endmodule

### rtl/mba_div.sv
// Radix-2 restoring divider, signed dividend by unsigned divisor, one bit a cycle.
// Quotient truncates toward zero. No package dependency.
`timescale 1ns / 1ps

module mba_div #(
  parameter int SUM_W = 33,
  parameter int DIV_W = 16,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    busy,
  output logic [Q_W-1:0]          quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W:0]   rem_sh;
  logic [SUM_W-1:0] q;
  logic [DIV_W-1:0] dvs;
  logic             neg;
  logic [CNT_W-1:0] steps;
  logic             fits;
  logic [SUM_W-1:0] q_signed;

  assign rem_sh   = {rem[DIV_W-1:0], q[SUM_W-1]};
  assign fits     = (rem_sh >= {1'b0, dvs});
  assign q_signed = neg ? (~q + SUM_W'(1)) : q;
  assign quotient = q_signed[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      dvs <= divisor;
      neg <= dividend[SUM_W-1];
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      q   <= {q[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= CNT_W'(SUM_W);
    end else if (busy) begin
      steps <= steps - CNT_W'(1);
      if (steps == CNT_W'(1)) busy <= 1'b0;
    end
  end

endmodule

### rtl/mba_back.sv
// Back end: per-channel state in RAM, accumulate/compare sequencer, divider, output register.
// Depends on mba_pkg, mba_ram and mba_div.
`timescale 1ns / 1ps

module mba_back
  import mba_pkg::*;
#(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  cmd_t                                  q_cmd,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((CHAN_W+SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

  localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS + 1;
  localparam int ENTRY_W = SUM_W + 2 * COUNT_BITS;
  localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OUT_W   = ((CHAN_W + SAMPLE_BITS + 7) / 8) * 8;

  back_state_t state, state_next;

  cmd_t                    cmd;
  logic [AW-1:0]           cmd_addr;
  logic [AW-1:0]           head_addr;
  logic [AW+CHAN_W-1:0]    cmd_ch_wide;
  logic [AW+CHAN_W-1:0]    head_ch_wide;
  logic [CHANNELS-1:0]     vld;
  logic [ENTRY_W-1:0]      rdata;
  logic [ENTRY_W-1:0]      wdata;
  logic                    we;

  logic signed [SUM_W-1:0] e_sum;
  logic [COUNT_BITS-1:0]   e_count;
  logic [COUNT_BITS-1:0]   e_target;
  logic [SAMPLE_BITS-1:0]  smp;
  logic signed [SUM_W-1:0] sum_n;
  logic [COUNT_BITS-1:0]   count_n;
  logic [COUNT_BITS-1:0]   new_target;
  logic                    complete;

  logic                    div_start;
  logic                    div_busy;
  logic [SAMPLE_BITS-1:0]  div_q;
  logic                    out_load;

  assign cmd_ch_wide  = (AW+CHAN_W)'(cmd.ch);
  assign head_ch_wide = (AW+CHAN_W)'(q_cmd.ch);
  assign cmd_addr     = cmd_ch_wide[AW-1:0];
  assign head_addr    = head_ch_wide[AW-1:0];

  mba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cmd_addr),
    .wdata (wdata),
    .raddr (head_addr),
    .rdata (rdata)
  );

  // unwritten channels read as sum 0, count 0, target 1
  always_comb begin
    if (vld[cmd_addr]) begin
      e_sum    = rdata[SUM_W-1:0];
      e_count  = rdata[SUM_W +: COUNT_BITS];
      e_target = rdata[SUM_W+COUNT_BITS +: COUNT_BITS];
    end else begin
      e_sum    = '0;
      e_count  = '0;
      e_target = COUNT_BITS'(1);
    end
  end

  assign smp        = cmd.data[SAMPLE_BITS-1:0];
  assign sum_n      = e_sum + SUM_W'($signed(smp));
  assign count_n    = e_count + COUNT_BITS'(1);
  assign complete   = (count_n == e_target);
  assign new_target = cmd.data[COUNT_BITS-1:0];

  mba_div #(
    .SUM_W (SUM_W),
    .DIV_W (COUNT_BITS),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_n),
    .divisor  (e_target),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid) state_next = ST_UPDATE;
      ST_UPDATE: state_next = (!cmd.set_count && complete) ? ST_DIVIDE : ST_IDLE;
      ST_DIVIDE: if (!div_busy) state_next = ST_EMIT;
      ST_EMIT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    we        = 1'b0;
    wdata     = {e_target, e_count, e_sum};
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: q_pop = q_valid;
      ST_UPDATE: begin
        if (cmd.set_count) begin
          we    = (new_target != e_target);
          wdata = {new_target, COUNT_BITS'(0), SUM_W'(0)};
        end else if (complete) begin
          we        = 1'b1;
          wdata     = {e_target, COUNT_BITS'(0), SUM_W'(0)};
          div_start = 1'b1;
        end else begin
          we    = 1'b1;
          wdata = {e_target, count_n, sum_n};
        end
      end
      ST_EMIT: out_load = !m_tvalid || m_tready;
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    if (out_load) m_tdata <= OUT_W'({div_q, cmd.ch});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) vld[cmd_addr] <= 1'b1;
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

endmodule

### rtl/multichannel_block_averager.sv
// Top level of the multichannel block averager (per-channel boxcar average and decimate).
// Depends on mba_pkg, mba_front, mba_queue and mba_back.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): one request per handshake. tuser = 0 carries a sample for
//   a channel, tuser = 1 loads that channel's averaging count (0 acts as 1).
//   Output stream (m_*): one request per completed average, channel and the
//   sum divided by the count, truncated toward zero.
//   Config channel (cfg_*): index 0 = first_channel, index 1 = last_channel;
//   always ready, write only while no request is in flight.
// Sequencing
//   The front takes a request whenever the two-entry queue has room. The back
//   handles a request that produces no result with a state RAM read, then an
//   update; one that completes an average also runs the bit-serial divider
//   and then loads the output register. The back pops no new request until
//   it returns to idle.
// Reset
//   Synchronous, active high. All channels read as sum 0, count 0, target 1,
//   the window opens to channels 0..15; no clearing pass is needed.
// Back-pressure
//   A result waits in the output register; the back stalls in front of it while
//   the queue keeps taking input until it fills, then s_tready drops.

module multichannel_block_averager
  import mba_pkg::*;
#(
  parameter int CHANNELS    = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // request input
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // tdata: channel[3:0], sample[SAMPLE_BITS], avg_count[COUNT_BITS], zero pad
  input  logic [((CHAN_W+SAMPLE_BITS+COUNT_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: func (0 = sample, 1 = set count)
  input  logic                                          s_tuser,
  // result output
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // tdata: out_channel[3:0], average[SAMPLE_BITS], zero pad
  output logic [((CHAN_W+SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
  // configuration writes
  input  logic                                          cfg_valid,
  output logic                                          cfg_ready,
  input  logic                                          cfg_index,
  input  logic [CHAN_W-1:0]                             cfg_data
);

  // front -> queue
  logic q_push;
  logic q_full;
  cmd_t push_cmd;
  // queue -> back
  logic q_pop;
  logic q_valid;
  cmd_t head_cmd;

  mba_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  // decouples acceptance from the state update and divide
  mba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (head_cmd)
  );

  mba_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
